/* design/pbb_pkg.sv */
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types and constants for the path bounding box block: coordinate
// type, path command codes and the command record held in the input stage.
// ----------------------------------------------------------------------------
package pbb_pkg;

    // Signed fixed point, 8 fraction bits
    localparam int COORD_WIDTH = 32;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // Path command codes
    typedef enum logic [1:0] {
        ACT_MOVE  = 2'd0,
        ACT_LINE  = 2'd1,
        ACT_CURVE = 2'd2,
        ACT_CLOSE = 2'd3
    } t_action;

    // One path command as held in the input register
    typedef struct packed {
        t_action action;
        t_coord  p1_x;
        t_coord  p1_y;
        t_coord  p2_x;
        t_coord  p2_y;
        t_coord  p3_x;
        t_coord  p3_y;
        logic    path_end;
    } t_cmd;

    // A compare candidate: a coordinate and whether it takes part
    typedef struct packed {
        logic   v;
        t_coord val;
    } t_cand;

endpackage

/* design/pbb_if.sv */
// ----------------------------------------------------------------------------
// Path bounding box channel interfaces
// Valid/ready channels for path commands in and bounding box results out.
// ----------------------------------------------------------------------------

// Path command channel
interface pbb_cmd_if import pbb_pkg::*; ();
    logic    valid;
    logic    ready;
    t_action action;
    t_coord  p1_x;
    t_coord  p1_y;
    t_coord  p2_x;
    t_coord  p2_y;
    t_coord  p3_x;
    t_coord  p3_y;
    logic    path_end;

    modport source (
        output valid, action, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, path_end,
        input  ready
    );
    modport sink (
        input  valid, action, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, path_end,
        output ready
    );
endinterface

// Bounding box result channel
interface pbb_box_if import pbb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord min_x;
    t_coord max_x;
    t_coord min_y;
    t_coord max_y;
    logic   empty_res;

    modport source (
        output valid, min_x, max_x, min_y, max_y, empty_res,
        input  ready
    );
    modport sink (
        input  valid, min_x, max_x, min_y, max_y, empty_res,
        output ready
    );
endinterface

/* design/path_bounding_box_core.sv */
// ----------------------------------------------------------------------------
// path_bounding_box_core
// Running bounding box of a vector path, one path command per request.
// ----------------------------------------------------------------------------
// A request marked path_end passes the input register, then the result register.
// Throughput: one command per cycle, but for stalls; the input register, a 5-way
//   compare tree per box edge and the result register form the single pass.
// The input stage stalls only while a path_end request waits on a full result
//   register. Reset (synchronous, active low) empties both stages and returns
//   the box to unseeded with the current point at the origin.
module path_bounding_box_core import pbb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pbb_cmd_if.sink       i_cmd,
    pbb_box_if.source     o_box
);

    // Smaller of two candidates; an unused candidate never wins
    function automatic t_cand pick_min(t_cand a, t_cand b);
        t_cand r;
        if (!a.v) begin
            r = b;
        end else if (!b.v) begin
            r = a;
        end else begin
            r = (b.val < a.val) ? b : a;
        end
        return r;
    endfunction

    // Larger of two candidates
    function automatic t_cand pick_max(t_cand a, t_cand b);
        t_cand r;
        if (!a.v) begin
            r = b;
        end else if (!b.v) begin
            r = a;
        end else begin
            r = (b.val > a.val) ? b : a;
        end
        return r;
    endfunction

    // Input stage
    logic   r_in_valid;
    t_cmd   r_cmd;

    // Path state
    t_coord r_cur_x;
    t_coord r_cur_y;
    logic   r_pending;
    logic   r_unseeded;
    t_coord r_box_min_x;
    t_coord r_box_max_x;
    t_coord r_box_min_y;
    t_coord r_box_max_y;

    // Result stage
    logic   r_out_valid;
    t_coord r_out_min_x;
    t_coord r_out_max_x;
    t_coord r_out_min_y;
    t_coord r_out_max_y;
    logic   r_out_empty;

    logic   out_free;
    logic   adv;
    logic   is_draw;
    logic   is_curve;
    logic   add_cur;
    logic   n_unseeded;

    t_cand  mnx_01, mnx_23, mnx_03, mnx;
    t_cand  mxx_01, mxx_23, mxx_03, mxx;
    t_cand  mny_01, mny_23, mny_03, mny;
    t_cand  mxy_01, mxy_23, mxy_03, mxy;

    // Handshake: the input stage moves on unless a result cannot be placed
    assign out_free    = !r_out_valid || o_box.ready;
    assign adv         = r_in_valid && (!r_cmd.path_end || out_free);
    assign i_cmd.ready = !r_in_valid || adv;

    assign is_draw  = (r_cmd.action == ACT_LINE) || (r_cmd.action == ACT_CURVE);
    assign is_curve = (r_cmd.action == ACT_CURVE);
    assign add_cur  = is_draw && r_pending;
    assign n_unseeded = r_unseeded && !is_draw;

    // Compare trees over old box, current point and p1..p3
    always_comb begin
        mnx_01 = pick_min({!r_unseeded, r_box_min_x}, {add_cur, r_cur_x});
        mnx_23 = pick_min({is_draw, r_cmd.p1_x}, {is_curve, r_cmd.p2_x});
        mnx_03 = pick_min(mnx_01, mnx_23);
        mnx    = pick_min(mnx_03, {is_curve, r_cmd.p3_x});

        mxx_01 = pick_max({!r_unseeded, r_box_max_x}, {add_cur, r_cur_x});
        mxx_23 = pick_max({is_draw, r_cmd.p1_x}, {is_curve, r_cmd.p2_x});
        mxx_03 = pick_max(mxx_01, mxx_23);
        mxx    = pick_max(mxx_03, {is_curve, r_cmd.p3_x});

        mny_01 = pick_min({!r_unseeded, r_box_min_y}, {add_cur, r_cur_y});
        mny_23 = pick_min({is_draw, r_cmd.p1_y}, {is_curve, r_cmd.p2_y});
        mny_03 = pick_min(mny_01, mny_23);
        mny    = pick_min(mny_03, {is_curve, r_cmd.p3_y});

        mxy_01 = pick_max({!r_unseeded, r_box_max_y}, {add_cur, r_cur_y});
        mxy_23 = pick_max({is_draw, r_cmd.p1_y}, {is_curve, r_cmd.p2_y});
        mxy_03 = pick_max(mxy_01, mxy_23);
        mxy    = pick_max(mxy_03, {is_curve, r_cmd.p3_y});
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= '{action: i_cmd.action, p1_x: i_cmd.p1_x, p1_y: i_cmd.p1_y,
                       p2_x: i_cmd.p2_x, p2_y: i_cmd.p2_y, p3_x: i_cmd.p3_x,
                       p3_y: i_cmd.p3_y, path_end: i_cmd.path_end};
        end
    end

    // Path state update; path_end returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_pending   <= 1'b1;
            r_unseeded  <= 1'b1;
            r_box_min_x <= '0;
            r_box_max_x <= '0;
            r_box_min_y <= '0;
            r_box_max_y <= '0;
        end else if (adv) begin
            if (r_cmd.path_end) begin
                r_cur_x     <= '0;
                r_cur_y     <= '0;
                r_pending   <= 1'b1;
                r_unseeded  <= 1'b1;
                r_box_min_x <= '0;
                r_box_max_x <= '0;
                r_box_min_y <= '0;
                r_box_max_y <= '0;
            end else begin
                unique case (r_cmd.action)
                    ACT_MOVE: begin
                        r_cur_x   <= r_cmd.p1_x;
                        r_cur_y   <= r_cmd.p1_y;
                        r_pending <= 1'b1;
                    end
                    ACT_CLOSE: begin
                        r_cur_x   <= '0;
                        r_cur_y   <= '0;
                        r_pending <= 1'b1;
                    end
                    default: begin
                        r_pending <= 1'b0;
                    end
                endcase
                r_unseeded  <= n_unseeded;
                r_box_min_x <= mnx.val;
                r_box_max_x <= mxx.val;
                r_box_min_y <= mny.val;
                r_box_max_y <= mxy.val;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_cmd.path_end) begin
            r_out_valid <= 1'b1;
        end else if (o_box.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_cmd.path_end) begin
            r_out_empty <= n_unseeded;
            r_out_min_x <= n_unseeded ? '0 : mnx.val;
            r_out_max_x <= n_unseeded ? '0 : mxx.val;
            r_out_min_y <= n_unseeded ? '0 : mny.val;
            r_out_max_y <= n_unseeded ? '0 : mxy.val;
        end
    end

    assign o_box.valid     = r_out_valid;
    assign o_box.min_x     = r_out_min_x;
    assign o_box.max_x     = r_out_max_x;
    assign o_box.min_y     = r_out_min_y;
    assign o_box.max_y     = r_out_max_y;
    assign o_box.empty_res = r_out_empty;

    // An empty path reports an all-zero box
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |->
            (r_out_min_x == '0 && r_out_max_x == '0 &&
             r_out_min_y == '0 && r_out_max_y == '0))
        else $error("empty result with nonzero box");

    // A filled box is never inverted
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_empty) |->
            (r_out_min_x <= r_out_max_x && r_out_min_y <= r_out_max_y))
        else $error("bounding box inverted");

    // Path end returns the path state to reset
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_cmd.path_end) |=>
            (r_unseeded && r_pending && r_cur_x == '0 && r_cur_y == '0))
        else $error("path state not cleared after path end");

endmodule
